>>> sv/assert_macros.svh
// Assertion macros shared by the radial gravity RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RGV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define RGV_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RGV_ASSERT(label, clk, rst_n, prop)
`define RGV_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> sv/rgv_pkg.sv
// Shared constants and types for the radial gravity velocity update.
// No dependencies.
package rgv_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DT_BITS = 16;
	localparam int DIV_W = 64;

	// configuration register indexes
	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_RADIUS   = 3'd3;
	localparam logic [2:0] REG_STRENGTH = 3'd4;
	localparam logic [2:0] REG_MODE     = 3'd5;

	// one stage of a restoring divider: remainder and quotient so far
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] quo;
	} div_state_t;
endpackage

>>> sv/rgv_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rgv_pkg. Quotient = floor(num / den); den must be non-zero.
module rgv_div import rgv_pkg::*; #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 64,
	parameter int TAG_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [TAG_W-1:0]  tag_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [TAG_W-1:0]  tag_out
);
	logic [NUM_W:0]        v_s;
	logic [NUM_W-1:0]      rem_s [NUM_W+1];
	logic [NUM_W-1:0]      q_s   [NUM_W+1];
	logic [NUM_W-1:0]      n_s   [NUM_W+1];
	logic [DEN_W-1:0]      d_s   [NUM_W+1];
	logic [TAG_W-1:0]      t_s   [NUM_W+1];

	always_comb begin
		rem_s[0] = '0;
		q_s[0]   = '0;
		n_s[0]   = num;
		d_s[0]   = den;
		t_s[0]   = tag_in;
	end
	assign v_s[0] = in_valid;

	// each stage shifts in one numerator bit and trial-subtracts
	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic [NUM_W:0] trial;
		assign trial = {rem_s[g], n_s[g][NUM_W-1-g]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {{(NUM_W+1-DEN_W){1'b0}}, d_s[g]}) begin
					rem_s[g+1] <= NUM_W'(trial - {{(NUM_W+1-DEN_W){1'b0}}, d_s[g]});
					q_s[g+1]   <= {q_s[g][NUM_W-2:0], 1'b1};
				end else begin
					rem_s[g+1] <= trial[NUM_W-1:0];
					q_s[g+1]   <= {q_s[g][NUM_W-2:0], 1'b0};
				end
				n_s[g+1] <= n_s[g];
				d_s[g+1] <= d_s[g];
				t_s[g+1] <= t_s[g];
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quo       = q_s[NUM_W];
	assign tag_out   = t_s[NUM_W];
endmodule

>>> sv/radial_gravity_velocity_update.sv
// Top level of the radial gravity velocity update pipeline.
// Depends on rgv_pkg, rgv_div and assert_macros.svh.
//
//  channel | valid    | stall     | payload
//  in      | in_valid | in_stall  | pos_*, vel_*, time_step
//  out     | out_valid| out_stall | new_vel_*, pulled
//  cfg     | cfg_we   | -         | cfg_index, cfg_data
//
// One body per cycle while the output is not stalled; 234 register stages:
// four front stages, 32 square-root stages, three 64-stage dividers in series
// (one bit per stage) and six single stages.
// The whole pipeline advances when the output is not stalled or empty;
// in_stall is high only while the pipe is frozen. Reset clears all valid bits.
`include "assert_macros.svh"
module radial_gravity_velocity_update import rgv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic               pulled
);
	localparam logic [63:0] SMALL_D2 =
		64'((((65'd1 << (2*FRAC_BITS)) - 65'd1)) / 65'd100000000);
	localparam logic [63:0] SAFE_MIN = 64'(64'd10 << FRAC_BITS);
	localparam int SQ_STEPS = 32;
	// carried payload: vel 96, diff mags 99, diff signs 3, dt 16, pulled 1,
	// mode 1, dist 32
	localparam int TAG_W = 96 + 99 + 3 + 16 + 1 + 1 + 32;

	// configuration registers
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [30:0]        rad_q;
	logic [31:0]        k_q;
	logic               mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			rad_q <= '0; k_q <= '0; mode_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				REG_CENTER_Z: cz_q <= cfg_data;
				REG_RADIUS:   rad_q <= cfg_data[30:0];
				REG_STRENGTH: k_q <= cfg_data;
				REG_MODE:     mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: whole pipe moves unless the held result is stalled
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: differences and magnitudes
	logic        v_s1;
	logic [32:0] m_s1 [3];
	logic [2:0]  neg_s1;
	logic [95:0] vel_s1;
	logic [15:0] dt_s1;
	logic signed [32:0] df [3];
	assign df[0] = 33'(cx_q) - 33'(pos_x);
	assign df[1] = 33'(cy_q) - 33'(pos_y);
	assign df[2] = 33'(cz_q) - 33'(pos_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= df[i][32];
				m_s1[i]   <= df[i][32] ? 33'(-df[i]) : 33'(df[i]);
			end
			vel_s1 <= {vel_z, vel_y, vel_x};
			dt_s1  <= time_step;
		end
	end

	// stage 2: squares (33x33 each, one per axis)
	logic        v_s2;
	logic [65:0] sq_s2 [3];
	logic [32:0] m_s2 [3];
	logic [2:0]  neg_s2;
	logic [95:0] vel_s2;
	logic [15:0] dt_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s2[i] <= m_s1[i] * m_s1[i];
			m_s2 <= m_s1; neg_s2 <= neg_s1; vel_s2 <= vel_s1; dt_s2 <= dt_s1;
		end
	end

	// stage 3: sum of squares, radius squared
	logic        v_s3;
	logic [67:0] d2_s3;
	logic [61:0] rsq_s3;
	logic [32:0] m_s3 [3];
	logic [2:0]  neg_s3;
	logic [95:0] vel_s3;
	logic [15:0] dt_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3  <= 68'(sq_s2[0]) + 68'(sq_s2[1]) + 68'(sq_s2[2]);
			rsq_s3 <= rad_q * rad_q;
			m_s3 <= m_s2; neg_s3 <= neg_s2; vel_s3 <= vel_s2; dt_s3 <= dt_s2;
		end
	end

	// stage 4: pulled decision
	logic        v_s4, pl_s4;
	logic [61:0] d2_s4;
	logic [32:0] m_s4 [3];
	logic [2:0]  neg_s4;
	logic [95:0] vel_s4;
	logic [15:0] dt_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s4 <= (d2_s3 <= 68'(rsq_s3)) && (d2_s3 > 68'(SMALL_D2)) && (rad_q != '0);
			d2_s4 <= d2_s3[61:0];
			m_s4 <= m_s3; neg_s4 <= neg_s3; vel_s4 <= vel_s3; dt_s4 <= dt_s3;
		end
	end

	// square root: one result bit per stage, d2 below 2^62
	logic        sv_q   [SQ_STEPS+1];
	logic [63:0] sx_q   [SQ_STEPS+1];
	logic [31:0] sr_q   [SQ_STEPS+1];
	logic [63:0] srem_q [SQ_STEPS+1];
	logic [TAG_W-1:0] stag_q [SQ_STEPS+1];
	always_comb begin
		sv_q[0]   = v_s4;
		sx_q[0]   = {2'b00, d2_s4};
		sr_q[0]   = '0;
		srem_q[0] = '0;
		stag_q[0] = {32'd0, mode_q, pl_s4, dt_s4, neg_s4,
			m_s4[2], m_s4[1], m_s4[0], vel_s4};
	end
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		logic [65:0] trem;
		logic [65:0] tsub;
		assign trem = {srem_q[g], sx_q[g][63-2*g -: 2]};
		assign tsub = {32'd0, sr_q[g], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv_q[g+1] <= 1'b0;
			else if (en) sv_q[g+1] <= sv_q[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (trem >= tsub) begin
					srem_q[g+1] <= 64'(trem - tsub);
					sr_q[g+1]   <= {sr_q[g][30:0], 1'b1};
				end else begin
					srem_q[g+1] <= trem[63:0];
					sr_q[g+1]   <= {sr_q[g][30:0], 1'b0};
				end
				sx_q[g+1]   <= sx_q[g];
				stag_q[g+1] <= stag_q[g];
			end
		end
	end

	// stage 5: dist clamp and first operand of strength
	logic        v_s5;
	logic [TAG_W-1:0] tag_s5;
	logic [63:0] num1_s5, den1_s5;
	logic [31:0] dist5;
	logic        mode5;
	assign dist5 = (sr_q[SQ_STEPS] == '0) ? 32'd1 : sr_q[SQ_STEPS];
	assign mode5 = stag_q[SQ_STEPS][TAG_W-33];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= sv_q[SQ_STEPS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s5 <= {dist5, stag_q[SQ_STEPS][TAG_W-33:0]};
			if (mode5) begin
				num1_s5 <= 64'(k_q) << FRAC_BITS;
				den1_s5 <= (64'(dist5) > SAFE_MIN) ? 64'(dist5) : SAFE_MIN;
			end else begin
				num1_s5 <= 64'(k_q) * 64'((rad_q > 31'(dist5)) ? rad_q - 31'(dist5) : 31'd0);
				den1_s5 <= (rad_q == '0) ? 64'd1 : 64'(rad_q);
			end
		end
	end

	// divider 1: q (inverse-square) or the final linear strength
	logic dv1_v;
	logic [63:0] dv1_q;
	logic [TAG_W+63:0] dv1_t;
	rgv_div #(.NUM_W(64), .DEN_W(64), .TAG_W(TAG_W+64)) u_div1 (
		.clk, .arst_n, .en, .in_valid(v_s5), .num(num1_s5), .den(den1_s5),
		.tag_in({den1_s5, tag_s5}), .out_valid(dv1_v), .quo(dv1_q), .tag_out(dv1_t)
	);

	// stage 6: second division operands; linear mode divides by one
	logic v_s6;
	logic [63:0] num2_s6, den2_s6;
	logic [TAG_W-1:0] tag_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= dv1_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s6 <= dv1_t[TAG_W-1:0];
			if (dv1_t[TAG_W-33]) begin
				num2_s6 <= dv1_q << FRAC_BITS;
				den2_s6 <= dv1_t[TAG_W+63:TAG_W];
			end else begin
				num2_s6 <= dv1_q;
				den2_s6 <= 64'd1;
			end
		end
	end

	logic dv2_v;
	logic [63:0] dv2_q;
	logic [TAG_W-1:0] dv2_t;
	rgv_div #(.NUM_W(64), .DEN_W(64), .TAG_W(TAG_W)) u_div2 (
		.clk, .arst_n, .en, .in_valid(v_s6), .num(num2_s6), .den(den2_s6),
		.tag_in(tag_s6), .out_valid(dv2_v), .quo(dv2_q), .tag_out(dv2_t)
	);

	// stage 7: strength clipped to 64 bits times each magnitude, split in
	// 32-bit partial products
	logic v_s7;
	logic [TAG_W-1:0] tag_s7;
	logic [64:0] plo_s7 [3];
	logic [64:0] phi_s7 [3];
	logic [32:0] mg7 [3];
	assign mg7[0] = dv2_t[128:96];
	assign mg7[1] = dv2_t[161:129];
	assign mg7[2] = dv2_t[194:162];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= dv2_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s7 <= dv2_t;
			for (int i = 0; i < 3; i++) begin
				plo_s7[i] <= mg7[i] * dv2_q[31:0];
				phi_s7[i] <= mg7[i] * dv2_q[63:32];
			end
		end
	end

	// stage 8: combine partial products (product kept to 64 bits)
	logic v_s8;
	logic [TAG_W-1:0] tag_s8;
	logic [63:0] pr_s8 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s8 <= tag_s7;
			for (int i = 0; i < 3; i++)
				pr_s8[i] <= 64'(plo_s7[i]) + (64'(phi_s7[i]) << 32);
		end
	end

	// three axis dividers by dist
	logic [2:0] av_v;
	logic [63:0] am [3];
	logic [TAG_W-1:0] at [3];
	for (genvar a = 0; a < 3; a++) begin : g_adiv
		rgv_div #(.NUM_W(64), .DEN_W(32), .TAG_W(TAG_W)) u_div (
			.clk, .arst_n, .en, .in_valid(v_s8), .num(pr_s8[a]),
			.den(tag_s8[TAG_W-1 -: 32]), .tag_in(tag_s8),
			.out_valid(av_v[a]), .quo(am[a]), .tag_out(at[a])
		);
	end

	// stage 9: a * dt in partial products
	logic v_s9;
	logic [TAG_W-1:0] tag_s9;
	logic [47:0] tlo_s9 [3];
	logic [47:0] thi_s9 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= av_v[0];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s9 <= at[0];
			for (int i = 0; i < 3; i++) begin
				tlo_s9[i] <= am[i][31:0] * at[0][213:198];
				thi_s9[i] <= am[i][63:32] * at[0][213:198];
			end
		end
	end

	// stage 10: shift by dt width; when pulled, add to velocity with saturation
	logic v_s10;
	logic [31:0] nv_s10 [3];
	logic pl_s10;
	logic [63:0] dm [3];
	logic signed [65:0] sum [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dm[i] = 64'((64'(tlo_s9[i]) + (64'(thi_s9[i]) << 32)) >> DT_BITS);
			sum[i] = 66'(signed'(tag_s9[32*i +: 32]))
				+ (tag_s9[195+i] ? -66'({2'b00, dm[i]}) : 66'({2'b00, dm[i]}));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s10 <= tag_s9[214];
			for (int i = 0; i < 3; i++) begin
				if (!tag_s9[214]) nv_s10[i] <= tag_s9[32*i +: 32];
				else if (sum[i] > 66'sd2147483647) nv_s10[i] <= 32'h7FFFFFFF;
				else if (sum[i] < -66'sd2147483648) nv_s10[i] <= 32'h80000000;
				else nv_s10[i] <= sum[i][31:0];
			end
		end
	end

	assign out_valid = v_s10;
	assign new_vel_x = nv_s10[0];
	assign new_vel_y = nv_s10[1];
	assign new_vel_z = nv_s10[2];
	assign pulled    = pl_s10;

	`RGV_ASSERT(a_stall_only_full, clk, arst_n, in_stall |-> out_valid)
	`RGV_ASSERT(a_hold_out, clk, arst_n, (out_valid && out_stall) |=> $stable(new_vel_x) && out_valid)
	`RGV_ASSERT(a_lanes_agree, clk, arst_n, av_v[0] == av_v[1] && av_v[1] == av_v[2])
	`RGV_ASSERT(a_out_known, clk, arst_n, out_valid |-> !$isunknown(pulled))
endmodule
